// ===== design/line_sensor_weight_slope_core_defines.svh =====
// Assertion macros shared by the line sensor weight slope checker.
`ifndef LINE_SENSOR_WEIGHT_SLOPE_CORE_DEFINES_SVH
`define LINE_SENSOR_WEIGHT_SLOPE_CORE_DEFINES_SVH

// Check that a condition implies another at the same edge.
`define LSWS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line sensor check failed");

// Check that a condition implies another at the next edge.
`define LSWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line sensor check failed");

`endif

// ===== design/lsws_pkg.sv =====
// Types and constants of the line sensor weight slope core.
package lsws_pkg;

    localparam int THRESH_W  = 10;
    localparam int WEIGHT_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int DEAD_W    = 31;
    localparam int SLOPE_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CHANNELS  = 3;

    localparam int DIFF_W  = WEIGHT_W + 1;
    localparam int PROD_W  = GAIN_W + DIFF_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int MAG_W   = 32;
    localparam int RECIP_W = 32;
    localparam int RECIP_SHIFT = 33;
    localparam logic [RECIP_W-1:0] RECIP_3 = 32'hAAAA_AAAB;

    localparam logic [THRESH_W-1:0]        RST_THRESHOLD = 10'd512;
    localparam logic signed [WEIGHT_W-1:0] RST_RISE      = 16'sd256;
    localparam logic signed [WEIGHT_W-1:0] RST_FALL      = -16'sd256;
    localparam logic signed [WEIGHT_W-1:0] RST_FLOOR     = -16'sd1024;
    localparam logic signed [WEIGHT_W-1:0] RST_CEIL      = 16'sd1024;
    localparam logic signed [GAIN_W-1:0]   RST_CGAIN     = 16'sd256;
    localparam logic signed [GAIN_W-1:0]   RST_LGAIN     = 16'sd256;
    localparam logic [DEAD_W-1:0]          RST_DEAD      = '0;

    localparam int CH_LEFT   = 0;
    localparam int CH_MIDDLE = 1;
    localparam int CH_RIGHT  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_RISE      = 3'd1,
        REG_FALL      = 3'd2,
        REG_FLOOR     = 3'd3,
        REG_CEIL      = 3'd4,
        REG_CGAIN     = 3'd5,
        REG_LGAIN     = 3'd6,
        REG_DEAD      = 3'd7
    } reg_idx_t;

    typedef logic signed [WEIGHT_W-1:0] weight_t;

    typedef struct packed {
        weight_t rise;
        weight_t fall;
        weight_t floor_w;
        weight_t ceil_w;
    } step_cfg_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] cgain;
        logic signed [GAIN_W-1:0] lgain;
        logic [DEAD_W-1:0]        dead;
    } slope_cfg_t;

    typedef struct packed {
        logic [CHANNELS-1:0] hits;
        weight_t             left_w;
        weight_t             middle_w;
        weight_t             right_w;
    } chan_t;

endpackage

// ===== design/lsws_lane.sv =====
// One sensor lane: threshold detect, held hit bit and clamped Q8.8 weight.
module lsws_lane
    import lsws_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [THRESH_W-1:0]    threshold,
    input  step_cfg_t              step_cfg,
    input  logic                   load,
    input  logic                   any_hit,
    output logic                   raw_hit,
    output logic                   hit,
    output weight_t                weight
);

    localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

    logic                      hit_reg;
    logic                      hit_next;
    weight_t                   weight_reg;
    weight_t                   weight_next;
    logic signed [WEIGHT_W:0]  sum;

    assign raw_hit  = CMP_W'(sample) > CMP_W'(threshold);
    assign hit_next = any_hit ? raw_hit : hit_reg;
    assign sum      = (WEIGHT_W + 1)'(weight_reg)
                    + (WEIGHT_W + 1)'(hit_next ? step_cfg.rise : step_cfg.fall);

    always_comb
    begin
        priority if (sum < (WEIGHT_W + 1)'(step_cfg.floor_w))
        begin
            weight_next = step_cfg.floor_w;
        end
        else if (sum > (WEIGHT_W + 1)'(step_cfg.ceil_w))
        begin
            weight_next = step_cfg.ceil_w;
        end
        else
        begin
            weight_next = sum[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg    <= 1'b0;
            weight_reg <= RST_CEIL;
        end
        else if (load)
        begin
            hit_reg    <= hit_next;
            weight_reg <= weight_next;
        end
    end

    assign hit    = hit_reg;
    assign weight = weight_reg;

endmodule

// ===== design/lsws_slope.sv =====
// Merge stage: pipelined slope from the three lane weights, divide by three, dead zone.
module lsws_slope
    import lsws_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  slope_cfg_t                slope_cfg,
    input  logic                      src_valid,
    input  chan_t                     src_chan,
    output logic                      src_ready,
    output logic                      dst_valid,
    input  logic                      dst_stall,
    output chan_t                     dst_chan,
    output logic signed [SLOPE_W-1:0] dst_slope
);

    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy2, rdy3, rdy4, rdy5;

    chan_t c2_reg, c3_reg, c4_reg, c5_reg;

    logic                      flip2_reg;
    logic signed [PROD_W-1:0]  p1_reg, p2_reg;
    logic                      branch_next;
    logic signed [DIFF_W-1:0]  d1_next, d2_next;
    logic signed [PROD_W-1:0]  p1_next, p2_next;

    logic                      neg3_reg;
    logic [MAG_W-1:0]          mag3_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   abs_next;

    logic                      neg4_reg;
    logic [MAG_W+RECIP_W-1:0]  prod4_reg;

    logic signed [SLOPE_W-1:0] slope5_reg;
    logic [DEAD_W-1:0]         quo;
    logic signed [SLOPE_W-1:0] slope_next;

    assign rdy5 = !v5_reg || !dst_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign src_ready = rdy2;

    // Products of gain and weight difference.
    always_comb
    begin
        branch_next = src_chan.left_w > src_chan.right_w;
        if (branch_next)
        begin
            d1_next = DIFF_W'(src_chan.middle_w) - DIFF_W'(src_chan.left_w);
            d2_next = DIFF_W'(src_chan.right_w) - DIFF_W'(src_chan.middle_w);
        end
        else
        begin
            d1_next = DIFF_W'(src_chan.middle_w) - DIFF_W'(src_chan.right_w);
            d2_next = DIFF_W'(src_chan.left_w) - DIFF_W'(src_chan.middle_w);
        end
        p1_next = PROD_W'(slope_cfg.cgain) * PROD_W'(d1_next);
        p2_next = PROD_W'(slope_cfg.lgain) * PROD_W'(d2_next);
    end

    // Sum, sign and magnitude.
    always_comb
    begin
        acc_next = ACC_W'(p1_reg) + ACC_W'(p2_reg);
        abs_next = acc_next[ACC_W-1] ? -acc_next : acc_next;
    end

    // Quotient by three, sign restore, dead zone.
    always_comb
    begin
        quo = prod4_reg[RECIP_SHIFT +: DEAD_W];
        if (quo < slope_cfg.dead)
        begin
            slope_next = '0;
        end
        else if (neg4_reg)
        begin
            slope_next = -$signed({1'b0, quo});
        end
        else
        begin
            slope_next = $signed({1'b0, quo});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= src_valid;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            c2_reg    <= src_chan;
            flip2_reg <= branch_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
        end
        if (rdy3)
        begin
            c3_reg   <= c2_reg;
            neg3_reg <= acc_next[ACC_W-1] ^ flip2_reg;
            mag3_reg <= abs_next[MAG_W-1:0];
        end
        if (rdy4)
        begin
            c4_reg    <= c3_reg;
            neg4_reg  <= neg3_reg;
            prod4_reg <= (MAG_W + RECIP_W)'(mag3_reg) * (MAG_W + RECIP_W)'(RECIP_3);
        end
        if (rdy5)
        begin
            c5_reg     <= c4_reg;
            slope5_reg <= slope_next;
        end
    end

    assign dst_valid = v5_reg;
    assign dst_chan  = c5_reg;
    assign dst_slope = slope5_reg;

endmodule

// ===== design/line_sensor_weight_slope_core.sv =====
// Top level of the three-channel line sensor weight and steering slope core.
// Accepts one sample triple per cycle while in_stall is low and returns one result per
// transaction, in order, after the lane registers and the merge pipeline. The three lanes
// update their held hit bit and Q8.8 weight in the accept cycle, a feedback loop per
// lane; the merge pipeline then forms the gain products, their sum and magnitude, the
// reciprocal multiply for the division by three, and the dead zone. Configuration
// writes are always taken; change registers only while no transaction is in flight.
module line_sensor_weight_slope_core
    import lsws_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [SAMPLE_BITS-1:0]    left_sample,
    input  logic [SAMPLE_BITS-1:0]    middle_sample,
    input  logic [SAMPLE_BITS-1:0]    right_sample,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      left_hit,
    output logic                      middle_hit,
    output logic                      right_hit,
    output logic signed [WEIGHT_W-1:0] left_weight,
    output logic signed [WEIGHT_W-1:0] middle_weight,
    output logic signed [WEIGHT_W-1:0] right_weight,
    output logic signed [SLOPE_W-1:0] steer_slope
);

    logic [THRESH_W-1:0] threshold_reg;
    step_cfg_t           step_cfg_reg;
    slope_cfg_t          slope_cfg_reg;

    logic                      v1_reg;
    logic                      v1_next;
    logic                      accept;
    logic                      rdy1;
    logic                      mrg_ready;
    logic [CHANNELS-1:0]       raw_hit;
    logic [CHANNELS-1:0]       hit;
    weight_t                   weight [CHANNELS];
    logic [SAMPLE_BITS-1:0]    sample [CHANNELS];
    chan_t                     lane_chan;
    chan_t                     out_chan;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg         <= RST_THRESHOLD;
            step_cfg_reg.rise     <= RST_RISE;
            step_cfg_reg.fall     <= RST_FALL;
            step_cfg_reg.floor_w  <= RST_FLOOR;
            step_cfg_reg.ceil_w   <= RST_CEIL;
            slope_cfg_reg.cgain   <= RST_CGAIN;
            slope_cfg_reg.lgain   <= RST_LGAIN;
            slope_cfg_reg.dead    <= RST_DEAD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_THRESHOLD: threshold_reg        <= cfg_data[THRESH_W-1:0];
                REG_RISE:      step_cfg_reg.rise    <= cfg_data[WEIGHT_W-1:0];
                REG_FALL:      step_cfg_reg.fall    <= cfg_data[WEIGHT_W-1:0];
                REG_FLOOR:     step_cfg_reg.floor_w <= cfg_data[WEIGHT_W-1:0];
                REG_CEIL:      step_cfg_reg.ceil_w  <= cfg_data[WEIGHT_W-1:0];
                REG_CGAIN:     slope_cfg_reg.cgain  <= cfg_data[GAIN_W-1:0];
                REG_LGAIN:     slope_cfg_reg.lgain  <= cfg_data[GAIN_W-1:0];
                REG_DEAD:      slope_cfg_reg.dead   <= cfg_data[DEAD_W-1:0];
            endcase
        end
    end

    // Lane stage holds the newest transaction until the merge pipeline takes it.
    assign rdy1     = !v1_reg || mrg_ready;
    assign in_stall = !rdy1;
    assign accept   = in_valid && rdy1;
    assign v1_next  = accept ? 1'b1 : (mrg_ready ? 1'b0 : v1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
        end
    end

    assign sample[CH_LEFT]   = left_sample;
    assign sample[CH_MIDDLE] = middle_sample;
    assign sample[CH_RIGHT]  = right_sample;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_lane
        lsws_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .sample    (sample[g]),
            .threshold (threshold_reg),
            .step_cfg  (step_cfg_reg),
            .load      (accept),
            .any_hit   (|raw_hit),
            .raw_hit   (raw_hit[g]),
            .hit       (hit[g]),
            .weight    (weight[g])
        );
    end

    assign lane_chan.hits     = hit;
    assign lane_chan.left_w   = weight[CH_LEFT];
    assign lane_chan.middle_w = weight[CH_MIDDLE];
    assign lane_chan.right_w  = weight[CH_RIGHT];

    lsws_slope u_slope (
        .clk       (clk),
        .rst_n     (rst_n),
        .slope_cfg (slope_cfg_reg),
        .src_valid (v1_reg),
        .src_chan  (lane_chan),
        .src_ready (mrg_ready),
        .dst_valid (out_valid),
        .dst_stall (out_stall),
        .dst_chan  (out_chan),
        .dst_slope (steer_slope)
    );

    assign left_hit      = out_chan.hits[CH_LEFT];
    assign middle_hit    = out_chan.hits[CH_MIDDLE];
    assign right_hit     = out_chan.hits[CH_RIGHT];
    assign left_weight   = out_chan.left_w;
    assign middle_weight = out_chan.middle_w;
    assign right_weight  = out_chan.right_w;

endmodule

// ===== design/lsws_checker.sv =====
// Port-level checker for the line sensor weight slope core and its bind.
`include "line_sensor_weight_slope_core_defines.svh"

module lsws_checker
    import lsws_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [WEIGHT_W-1:0] left_weight,
    input logic signed [WEIGHT_W-1:0] middle_weight,
    input logic signed [WEIGHT_W-1:0] right_weight,
    input logic signed [SLOPE_W-1:0]  steer_slope
);

    logic level_weights;

    assign level_weights = (left_weight == middle_weight) && (middle_weight == right_weight);

    `LSWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `LSWS_ASSERT_NEXT(a_slope_hold, clk, rst_n, out_valid && out_stall, $stable(steer_slope))
    `LSWS_ASSERT_SAME(a_empty_accepts, clk, rst_n, !out_valid, !in_stall)
    `LSWS_ASSERT_SAME(a_level_zero, clk, rst_n, out_valid && level_weights, steer_slope == '0)
    `LSWS_ASSERT_SAME(a_slope_bound, clk, rst_n, out_valid, steer_slope != {1'b1, {(SLOPE_W-1){1'b0}}})

endmodule

bind line_sensor_weight_slope_core lsws_checker u_lsws_checker (.*);

// ===== tb/sv/line_sensor_weight_slope_core_test.sv =====
// Self-checking testbench of the line sensor weight and steering slope core.
module line_sensor_weight_slope_core_test;
    import lsws_pkg::*;

    localparam int SAMPLE_W        = 10;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int QUIET_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 12;
    localparam longint SLOPE_MAX   = 64'sd2147483647;
    localparam longint SLOPE_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic                      left_hit;
        logic                      middle_hit;
        logic                      right_hit;
        weight_t                   left_weight;
        weight_t                   middle_weight;
        weight_t                   right_weight;
        logic signed [SLOPE_W-1:0] steer_slope;
    } lane_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] middle_sample;
    logic [SAMPLE_W-1:0] right_sample;
    logic out_valid;
    logic out_stall;
    logic left_hit;
    logic middle_hit;
    logic right_hit;
    logic signed [WEIGHT_W-1:0] left_weight;
    logic signed [WEIGHT_W-1:0] middle_weight;
    logic signed [WEIGHT_W-1:0] right_weight;
    logic signed [SLOPE_W-1:0] steer_slope;

    logic [THRESH_W-1:0]      thr_q    = RST_THRESHOLD;
    weight_t                  rise_q   = RST_RISE;
    weight_t                  fall_q   = RST_FALL;
    weight_t                  floor_q  = RST_FLOOR;
    weight_t                  ceil_q   = RST_CEIL;
    logic signed [GAIN_W-1:0] cgain_q  = RST_CGAIN;
    logic signed [GAIN_W-1:0] lgain_q  = RST_LGAIN;
    logic [DEAD_W-1:0]        dead_q   = RST_DEAD;
    logic [CHANNELS-1:0]      held_hits = '0;
    weight_t                  lane_weight [CHANNELS] = '{default: RST_CEIL};

    lane_result_t expected_results [$];
    lane_result_t oldest_result;
    int fail_count   = 0;
    int quiet_cycles = 0;
    int in_idle_pct  = 10;
    int stall_pct    = 10;
    int hold_cycles  = 0;

    line_sensor_weight_slope_core #(.SAMPLE_BITS(SAMPLE_W)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left_sample   (left_sample),
        .middle_sample (middle_sample),
        .right_sample  (right_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_hit      (left_hit),
        .middle_hit    (middle_hit),
        .right_hit     (right_hit),
        .left_weight   (left_weight),
        .middle_weight (middle_weight),
        .right_weight  (right_weight),
        .steer_slope   (steer_slope)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic lane_result_t predict_lanes(logic [SAMPLE_W-1:0] l_smp,
                                                   logic [SAMPLE_W-1:0] m_smp,
                                                   logic [SAMPLE_W-1:0] r_smp);
        logic [CHANNELS-1:0] fresh;
        int next_w;
        longint l, m, r, cg, lg, acc, s, mag;
        lane_result_t res;
        fresh[CH_LEFT]   = l_smp > thr_q;
        fresh[CH_MIDDLE] = m_smp > thr_q;
        fresh[CH_RIGHT]  = r_smp > thr_q;
        if (fresh != '0)
            held_hits = fresh;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            next_w = int'(lane_weight[ch]) + int'(held_hits[ch] ? rise_q : fall_q);
            if (next_w < int'(floor_q))
                lane_weight[ch] = floor_q;
            else if (next_w > int'(ceil_q))
                lane_weight[ch] = ceil_q;
            else
                lane_weight[ch] = weight_t'(next_w);
        end
        l  = lane_weight[CH_LEFT];
        m  = lane_weight[CH_MIDDLE];
        r  = lane_weight[CH_RIGHT];
        cg = cgain_q;
        lg = lgain_q;
        if (l > r)
        begin
            acc = cg * (m - l) + lg * (r - m);
            s   = -acc / 3;
        end
        else
        begin
            acc = cg * (m - r) + lg * (l - m);
            s   = acc / 3;
        end
        if (s > SLOPE_MAX)
            s = SLOPE_MAX;
        if (s < SLOPE_MIN)
            s = SLOPE_MIN;
        mag = (s < 0) ? -s : s;
        if (mag < longint'({33'd0, dead_q}))
            s = 0;
        res.left_hit      = held_hits[CH_LEFT];
        res.middle_hit    = held_hits[CH_MIDDLE];
        res.right_hit     = held_hits[CH_RIGHT];
        res.left_weight   = lane_weight[CH_LEFT];
        res.middle_weight = lane_weight[CH_MIDDLE];
        res.right_weight  = lane_weight[CH_RIGHT];
        res.steer_slope   = s[SLOPE_W-1:0];
        return res;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no expected result pending");
                fail_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                compare_field("left_hit", oldest_result.left_hit, left_hit);
                compare_field("middle_hit", oldest_result.middle_hit, middle_hit);
                compare_field("right_hit", oldest_result.right_hit, right_hit);
                compare_field("left_weight", oldest_result.left_weight, left_weight);
                compare_field("middle_weight", oldest_result.middle_weight, middle_weight);
                compare_field("right_weight", oldest_result.right_weight, right_weight);
                compare_field("steer_slope", oldest_result.steer_slope, steer_slope);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles != 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] l_smp,
                               input logic [SAMPLE_W-1:0] m_smp,
                               input logic [SAMPLE_W-1:0] r_smp);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        left_sample   <= l_smp;
        middle_sample <= m_smp;
        right_sample  <= r_smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_lanes(l_smp, m_smp, r_smp));
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int near;
        case ($urandom_range(3))
            0: return SAMPLE_W'($urandom);
            1:
            begin
                near = int'(thr_q) + int'($urandom_range(6)) - 3;
                if (near < 0)
                    near = 0;
                if (near > 1023)
                    near = 1023;
                return SAMPLE_W'(near);
            end
            2: return $urandom_range(1) ? '1 : '0;
            default: return SAMPLE_W'($urandom_range(int'(thr_q)));
        endcase
    endfunction

    task automatic send_random_sample();
        if ($urandom_range(4) == 0)
            send_sample(SAMPLE_W'($urandom_range(int'(thr_q))),
                        SAMPLE_W'($urandom_range(int'(thr_q))),
                        SAMPLE_W'($urandom_range(int'(thr_q))));
        else
            send_sample(pick_sample(), pick_sample(), pick_sample());
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_DATA_W-1:0] word;
        junk = $urandom;
        case (idx)
            REG_THRESHOLD: word = {junk[31:10], value[9:0]};
            REG_DEAD:      word = {junk[31], value[30:0]};
            default:       word = {junk[31:16], value[15:0]};
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_THRESHOLD: thr_q   = word[THRESH_W-1:0];
            REG_RISE:      rise_q  = word[WEIGHT_W-1:0];
            REG_FALL:      fall_q  = word[WEIGHT_W-1:0];
            REG_FLOOR:     floor_q = word[WEIGHT_W-1:0];
            REG_CEIL:      ceil_q  = word[WEIGHT_W-1:0];
            REG_CGAIN:     cgain_q = word[GAIN_W-1:0];
            REG_LGAIN:     lgain_q = word[GAIN_W-1:0];
            REG_DEAD:      dead_q  = word[DEAD_W-1:0];
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [THRESH_W-1:0] thr, input weight_t rise,
                             input weight_t fall, input weight_t lo, input weight_t hi,
                             input weight_t cg, input weight_t lg,
                             input logic [DEAD_W-1:0] dz);
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_RISE, CFG_DATA_W'(rise));
        write_reg(REG_FALL, CFG_DATA_W'(fall));
        write_reg(REG_FLOOR, CFG_DATA_W'(lo));
        write_reg(REG_CEIL, CFG_DATA_W'(hi));
        write_reg(REG_CGAIN, CFG_DATA_W'(cg));
        write_reg(REG_LGAIN, CFG_DATA_W'(lg));
        write_reg(REG_DEAD, CFG_DATA_W'(dz));
    endtask

    function automatic weight_t pick_weight();
        case ($urandom_range(3))
            0: return weight_t'(int'($urandom_range(1024)) - 512);
            1: return weight_t'($urandom);
            2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return weight_t'((int'($urandom_range(8)) - 4) * 64);
        endcase
    endfunction

    task automatic randomize_config();
        weight_t lo, hi, swap;
        logic [THRESH_W-1:0] thr;
        logic [DEAD_W-1:0] dz;
        lo = pick_weight();
        hi = pick_weight();
        if (lo > hi && $urandom_range(6) != 0)
        begin
            swap = lo;
            lo   = hi;
            hi   = swap;
        end
        case ($urandom_range(3))
            0: thr = $urandom_range(1) ? '1 : '0;
            1: thr = THRESH_W'($urandom_range(560, 460));
            default: thr = THRESH_W'($urandom);
        endcase
        case ($urandom_range(9))
            0: dz = DEAD_W'($urandom);
            1, 2, 3: dz = DEAD_W'($urandom_range(32'h00FF_FFFF));
            default: dz = '0;
        endcase
        configure(thr, pick_weight(), pick_weight(), lo, hi, pick_weight(), pick_weight(), dz);
    endtask

    task automatic test_reset_defaults();
        send_sample(10'd0, 10'd0, 10'd0);
        send_sample(10'd1023, 10'd1023, 10'd1023);
        send_sample(10'd512, 10'd512, 10'd512);
        send_sample(10'd513, 10'd0, 10'd0);
        send_sample(10'd0, 10'd513, 10'd0);
        send_sample(10'd0, 10'd0, 10'd513);
        send_sample(10'd1023, 10'd0, 10'd1023);
        send_sample(10'd0, 10'd0, 10'd0);
        send_sample(10'd511, 10'd700, 10'd0);
        settle();
    endtask

    task automatic test_threshold_edges();
        configure(10'd0, 16'sd256, -16'sd256, -16'sd1024, 16'sd1024, 16'sd256, 16'sd256, '0);
        send_sample(10'd0, 10'd0, 10'd0);
        send_sample(10'd1, 10'd0, 10'd0);
        send_sample(10'd0, 10'd0, 10'd1);
        settle();
        write_reg(REG_THRESHOLD, 32'd1023);
        send_sample(10'd1023, 10'd1023, 10'd1023);
        send_sample(10'd1022, 10'd0, 10'd1023);
        settle();
    endtask

    task automatic test_clamp_bounds();
        configure(10'd512, 16'sd300, -16'sd300, 16'sd1000, -16'sd1000, 16'sd256, 16'sd256, '0);
        send_sample(10'd1023, 10'd0, 10'd0);
        send_sample(10'd0, 10'd0, 10'd0);
        settle();
        write_reg(REG_FLOOR, CFG_DATA_W'(-16'sd512));
        write_reg(REG_CEIL, 32'd512);
        send_sample(10'd1023, 10'd1023, 10'd0);
        send_sample(10'd0, 10'd1023, 10'd0);
        settle();
    endtask

    task automatic test_slope_extremes();
        configure(10'd512, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                  '0);
        send_sample(10'd1023, 10'd0, 10'd0);
        send_sample(10'd0, 10'd0, 10'd1023);
        send_sample(10'd1023, 10'd1023, 10'd0);
        send_sample(10'd0, 10'd1023, 10'd1023);
        send_sample(10'd0, 10'd0, 10'd0);
        settle();
        write_reg(REG_DEAD, 32'h7FFF_FFFF);
        send_sample(10'd1023, 10'd0, 10'd0);
        send_sample(10'd0, 10'd0, 10'd1023);
        settle();
        write_reg(REG_CGAIN, 32'h7FFF);
        write_reg(REG_LGAIN, 32'h8000);
        write_reg(REG_DEAD, 32'h0001_0000);
        send_sample(10'd1023, 10'd0, 10'd0);
        send_sample(10'd0, 10'd1023, 10'd1023);
        settle();
    endtask

    task automatic test_backpressure();
        randomize_config();
        in_idle_pct = 0;
        stall_pct   = 0;
        hold_cycles <= 60;
        repeat (24) send_random_sample();
        settle();
        in_idle_pct = 10;
        stall_pct   = 10;
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            randomize_config();
            if (phase == PHASES / 2)
            begin
                in_idle_pct = 0;
                stall_pct   = 0;
            end
            else
            begin
                in_idle_pct = 10;
                stall_pct   = 10;
            end
            repeat (ITEMS_PER_PHASE) send_random_sample();
            settle();
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_THRESHOLD;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        left_sample   <= '0;
        middle_sample <= '0;
        right_sample  <= '0;
        out_stall     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_threshold_edges();
        test_clamp_bounds();
        test_slope_extremes();
        test_backpressure();
        test_random_phases();
        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/lsws_pkg.sv
design/lsws_lane.sv
design/lsws_slope.sv
design/line_sensor_weight_slope_core.sv
design/lsws_checker.sv
tb/sv/line_sensor_weight_slope_core_test.sv
